// ----- rtl/bb3e_pkg.sv -----
// bb3e_pkg: types and constants shared by the 3x3 box blur block.
// No dependencies; every rtl file imports it.
package bb3e_pkg;

  // queue depths between the parts
  localparam int JOB_DEPTH = 4;
  localparam int JOB_LVL_W = $clog2(JOB_DEPTH + 1);
  localparam int OUT_DEPTH = 4;

  // configuration register widths
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 13;

  // input opcodes
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  // register index, taken from paddr[2]
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic       op;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       frame_end;
    logic       run_last;
  } out_item_t;

  // one result to compute from a window: cols[0] is the oldest column
  typedef struct packed {
    logic       emit;
    logic [2:0] cols;
    logic       frame_end;
    logic       run_last;
  } res_desc_t;

  // window snapshot plus up to two results; rows[0] is the top row
  typedef struct packed {
    pixel_t [8:0] win;
    logic [2:0]   rows;
    res_desc_t    res_a;
    res_desc_t    res_b;
  } job_t;

endpackage

// ----- rtl/bb3e_front.sv -----
// bb3e_front: accepts items, keeps frame position, line stores and window,
// and hands finished windows to the job queue. Depends on bb3e_pkg.
module bb3e_front import bb3e_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    restart,
  input  logic [WIDTH_REG_W-1:0]  image_width,
  input  logic [HEIGHT_REG_W-1:0] image_height,
  input  logic                    push,
  output logic                    full,
  input  in_item_t                item,
  input  logic [JOB_LVL_W-1:0]    job_level,
  output logic                    job_push,
  output job_t                    job
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT + 1);

  typedef enum logic [1:0] {
    ST_RUN   = 2'b01,
    ST_PRIME = 2'b10
  } state_t;

  typedef struct packed {
    logic          valid;
    logic          wr;
    logic [CW-1:0] addr;
    pixel_t        pix;
    logic [2:0]    rows;
    res_desc_t     res_a;
    res_desc_t     res_b;
  } op_t;

  state_t state, state_next;
  op_t    f2, f2_next, pend, pix_op, drain_op, prime_op;

  logic [CW-1:0] in_column, drain_col;
  logic [RW-1:0] in_row;

  pixel_t mem_older [MAX_WIDTH];
  pixel_t mem_prev  [MAX_WIDTH];
  pixel_t rd_older, rd_prev, byp_older, byp_prev, t_eff, m_eff;
  logic   byp_valid;

  pixel_t       win [9];
  pixel_t [8:0] win_new;

  logic [31:0] w_m1;
  logic acc, take_pix, take_drain, loaded, col_last, d_last;
  logic r_ge1, r_ge2, c_ge1, c_ge2, d_ge1, h_ge2, e1, e2;

  assign w_m1     = 32'(image_width) - 32'd1;
  assign loaded   = 32'(in_row) >= 32'(image_height);
  assign col_last = 32'(in_column) == w_m1;
  assign d_last   = 32'(drain_col) == w_m1;
  assign r_ge1    = in_row != '0;
  assign r_ge2    = 32'(in_row) >= 32'd2;
  assign c_ge1    = in_column != '0;
  assign c_ge2    = 32'(in_column) >= 32'd2;
  assign d_ge1    = drain_col != '0;
  assign h_ge2    = image_height >= HEIGHT_REG_W'(2);
  assign e1       = r_ge1 && c_ge1;
  assign e2       = r_ge1 && col_last;

  // one job slot is reserved per item in flight, so f2 never stalls
  assign full = (state == ST_PRIME) ||
                ((32'(job_level) + 32'(f2.valid)) >= JOB_DEPTH);
  assign acc        = push && !full;
  assign take_pix   = acc && (item.op == OP_PIXEL) && !loaded;
  assign take_drain = acc && (item.op == OP_DRAIN) && loaded;

  always_comb begin
    pix_op       = '0;
    pix_op.valid = 1'b1;
    pix_op.wr    = 1'b1;
    pix_op.addr  = in_column;
    pix_op.pix   = '{red: item.in_red, green: item.in_green, blue: item.in_blue};
    pix_op.rows  = {1'b1, 1'b1, r_ge2};
    pix_op.res_a = '{emit: e1, cols: {1'b1, 1'b1, c_ge2}, frame_end: 1'b0,
                     run_last: !e2};
    pix_op.res_b = '{emit: e2, cols: {1'b1, c_ge1, 1'b0}, frame_end: 1'b0,
                     run_last: 1'b1};

    // drain shifts in the column right of the one it emits
    drain_op       = '0;
    drain_op.valid = 1'b1;
    drain_op.addr  = drain_col + CW'(1);
    drain_op.rows  = {1'b0, 1'b1, h_ge2};
    drain_op.res_a = '{emit: 1'b1, cols: {!d_last, 1'b1, d_ge1}, frame_end: d_last,
                       run_last: 1'b1};

    // first drain of a frame loads column 0 before its own read
    prime_op       = '0;
    prime_op.valid = 1'b1;
  end

  always_comb begin
    f2_next    = '0;
    state_next = state;
    case (state)
      ST_PRIME: begin
        f2_next    = pend;
        state_next = ST_RUN;
      end
      ST_RUN: begin
        if (take_pix) begin
          f2_next = pix_op;
        end else if (take_drain) begin
          if (drain_col == '0) begin
            f2_next    = prime_op;
            state_next = ST_PRIME;
          end else begin
            f2_next = drain_op;
          end
        end
      end
      default: state_next = ST_RUN;
    endcase
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_RUN;
      f2        <= '0;
      in_column <= '0;
      in_row    <= '0;
      drain_col <= '0;
      byp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      f2        <= f2_next;
      byp_valid <= f2.valid && f2.wr && (f2.addr == f2_next.addr);
      if (restart) begin
        in_column <= '0;
        in_row    <= '0;
        drain_col <= '0;
      end else if (take_pix) begin
        if (col_last) begin
          in_column <= '0;
          in_row    <= in_row + RW'(1);
        end else begin
          in_column <= in_column + CW'(1);
        end
      end else if (take_drain) begin
        if (d_last) begin
          in_column <= '0;
          in_row    <= '0;
          drain_col <= '0;
        end else begin
          drain_col <= drain_col + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_drain) begin
      pend <= drain_op;
    end
  end

  // line stores: one read and one write per cycle each
  always_ff @(posedge clk) begin
    rd_older <= mem_older[f2_next.addr];
    rd_prev  <= mem_prev[f2_next.addr];
    if (f2.valid && f2.wr) begin
      mem_older[f2.addr] <= m_eff;
      mem_prev[f2.addr]  <= f2.pix;
    end
    byp_older <= m_eff;
    byp_prev  <= f2.pix;
  end

  // forward a write that landed on the same edge as this read
  assign t_eff = byp_valid ? byp_older : rd_older;
  assign m_eff = byp_valid ? byp_prev : rd_prev;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      win_new[i*3]   = win[i*3+1];
      win_new[i*3+1] = win[i*3+2];
    end
    win_new[2] = t_eff;
    win_new[5] = m_eff;
    win_new[8] = f2.pix;
  end

  always_ff @(posedge clk) begin
    if (f2.valid) begin
      for (int k = 0; k < 9; k++) begin
        win[k] <= win_new[k];
      end
    end
  end

  assign job_push = f2.valid && (f2.res_a.emit || f2.res_b.emit);
  assign job = '{win: win_new, rows: f2.rows, res_a: f2.res_a, res_b: f2.res_b};

endmodule

// ----- rtl/bb3e_job_fifo.sv -----
// bb3e_job_fifo: short queue of window jobs between front and back.
// Depends on bb3e_pkg.
module bb3e_job_fifo import bb3e_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr,
  input  job_t                 wr_data,
  input  logic                 rd,
  output job_t                 rd_data,
  output logic                 empty,
  output logic [JOB_LVL_W-1:0] level
);

  localparam int PW = $clog2(JOB_DEPTH);

  job_t          mem [JOB_DEPTH];
  logic [PW-1:0] wptr, rptr;

  assign empty   = level == '0;
  assign rd_data = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      level <= '0;
    end else begin
      if (wr) begin
        wptr <= wptr + PW'(1);
      end
      if (rd) begin
        rptr <= rptr + PW'(1);
      end
      level <= level + JOB_LVL_W'(wr) - JOB_LVL_W'(rd);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wptr] <= wr_data;
    end
  end

endmodule

// ----- rtl/bb3e_back.sv -----
// bb3e_back: turns window jobs into averaged pixels and queues them for output.
// Depends on bb3e_pkg.
module bb3e_back import bb3e_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  job_t      job,
  input  logic      job_empty,
  output logic      job_pop,
  output out_item_t result,
  output logic      empty,
  input  logic      pop
);

  localparam int OPW = $clog2(OUT_DEPTH);
  localparam int OCW = $clog2(OUT_DEPTH + 1);
  localparam int RECIP_SHIFT = 16;

  typedef struct packed {
    logic        valid;
    logic [11:0] sum_r;
    logic [11:0] sum_g;
    logic [11:0] sum_b;
    logic [3:0]  cnt;
    logic        frame_end;
    logic        run_last;
  } sum_t;

  // ceil(2^16 / n); exact floor division for sums below 2^15
  function automatic logic [16:0] recip(input logic [3:0] n);
    logic [16:0] m;
    case (n)
      4'd2:    m = 17'd32768;
      4'd3:    m = 17'd21846;
      4'd4:    m = 17'd16384;
      4'd6:    m = 17'd10923;
      4'd9:    m = 17'd7282;
      default: m = 17'd65536;
    endcase
    return m;
  endfunction

  sum_t        s1;
  res_desc_t   desc;
  logic        half, sel_b, issue, do_pop;
  logic [11:0] sr, sg, sb, xr, xg, xb;
  logic [1:0]  rn, cn;
  logic [3:0]  cnt;
  logic [16:0] m;
  logic [28:0] pr, pg, pb;
  out_item_t   res_new;

  out_item_t      mem [OUT_DEPTH];
  logic [OPW-1:0] wptr, rptr;
  logic [OCW-1:0] o_count;

  // result a first, then b from the same job
  assign sel_b   = half || !job.res_a.emit;
  assign desc    = sel_b ? job.res_b : job.res_a;
  assign issue   = !job_empty && ((32'(o_count) + 32'(s1.valid)) < OUT_DEPTH);
  assign job_pop = issue && (sel_b || !job.res_b.emit);

  always_comb begin
    sr = '0;
    sg = '0;
    sb = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (job.rows[i] && desc.cols[j]) begin
          sr = sr + 12'(job.win[i*3+j].red);
          sg = sg + 12'(job.win[i*3+j].green);
          sb = sb + 12'(job.win[i*3+j].blue);
        end
      end
    end
    rn  = 2'($countones(job.rows));
    cn  = 2'($countones(desc.cols));
    cnt = 4'(rn) * 4'(cn);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      half     <= 1'b0;
      s1.valid <= 1'b0;
    end else begin
      s1.valid <= issue;
      if (job_pop) begin
        half <= 1'b0;
      end else if (issue) begin
        half <= 1'b1;
      end
      if (issue) begin
        s1.sum_r     <= sr;
        s1.sum_g     <= sg;
        s1.sum_b     <= sb;
        s1.cnt       <= cnt;
        s1.frame_end <= desc.frame_end;
        s1.run_last  <= desc.run_last;
      end
    end
  end

  // round half up, then divide by reciprocal multiply
  always_comb begin
    m  = recip(s1.cnt);
    xr = s1.sum_r + 12'(s1.cnt >> 1);
    xg = s1.sum_g + 12'(s1.cnt >> 1);
    xb = s1.sum_b + 12'(s1.cnt >> 1);
    pr = 29'(xr) * 29'(m);
    pg = 29'(xg) * 29'(m);
    pb = 29'(xb) * 29'(m);
    res_new = '{out_red: pr[RECIP_SHIFT +: 8], out_green: pg[RECIP_SHIFT +: 8],
                out_blue: pb[RECIP_SHIFT +: 8], frame_end: s1.frame_end,
                run_last: s1.run_last};
  end

  // output queue
  assign empty  = o_count == '0;
  assign do_pop = pop && !empty;
  assign result = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr    <= '0;
      rptr    <= '0;
      o_count <= '0;
    end else begin
      if (s1.valid) begin
        wptr <= wptr + OPW'(1);
      end
      if (do_pop) begin
        rptr <= rptr + OPW'(1);
      end
      o_count <= o_count + OCW'(s1.valid) - OCW'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (s1.valid) begin
      mem[wptr] <= res_new;
    end
  end

endmodule

// ----- rtl/box_blur_3x3_edge_aware.sv -----
// box_blur_3x3_edge_aware: streaming edge-aware 3x3 box blur, RGB 8/8/8.
// Path: item -> f2 -> job queue -> s1 -> output queue; a second result from a job follows.
//   The first drain of a frame also passes ST_PRIME (single line-store read port).
// Throughput: one item per cycle unless full (no job slot, or the prime step of a frame's
//   first drain); the back end gives one result per cycle while the output queue has room.
// Reset: positions, queues and handshakes clear; width and height return to 1.
//   Line stores are not cleared and need no clearing pass.
module box_blur_3x3_edge_aware import bb3e_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic        clk,
  input  logic        rst,
  // input queue side
  input  logic        push,
  output logic        full,
  input  in_item_t    item,
  // result queue side
  output logic        empty,
  input  logic        pop,
  output out_item_t   result,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // configuration registers
  logic [WIDTH_REG_W-1:0]  image_width, width_wr;
  logic [HEIGHT_REG_W-1:0] image_height, height_wr;
  logic                    cfg_wr;

  // front to queue to back
  job_t                 job_in, job_head;
  logic                 job_push, job_pop, job_empty;
  logic [JOB_LVL_W-1:0] job_level;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_IMAGE_HEIGHT) ? 32'(image_height)
                                                 : 32'(image_width);

  // clamp writes into 1..MAX
  always_comb begin
    width_wr = pwdata[WIDTH_REG_W-1:0];
    if (width_wr == '0) begin
      width_wr = WIDTH_REG_W'(1);
    end else if (32'(width_wr) > MAX_WIDTH) begin
      width_wr = WIDTH_REG_W'(MAX_WIDTH);
    end
    height_wr = pwdata[HEIGHT_REG_W-1:0];
    if (height_wr == '0) begin
      height_wr = HEIGHT_REG_W'(1);
    end else if (32'(height_wr) > MAX_HEIGHT) begin
      height_wr = HEIGHT_REG_W'(MAX_HEIGHT);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_REG_W'(1);
      image_height <= HEIGHT_REG_W'(1);
    end else if (cfg_wr) begin
      if (paddr[2] == REG_IMAGE_HEIGHT) begin
        image_height <= height_wr;
      end else begin
        image_width <= width_wr;
      end
    end
  end

  // any register write restarts the frame (cfg_wr drives restart)
  bb3e_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .restart     (cfg_wr),
    .image_width (image_width),
    .image_height(image_height),
    .push        (push),
    .full        (full),
    .item        (item),
    .job_level   (job_level),
    .job_push    (job_push),
    .job         (job_in)
  );

  bb3e_job_fifo u_jobs (
    .clk    (clk),
    .rst    (rst),
    .wr     (job_push),
    .wr_data(job_in),
    .rd     (job_pop),
    .rd_data(job_head),
    .empty  (job_empty),
    .level  (job_level)
  );

  bb3e_back u_back (
    .clk      (clk),
    .rst      (rst),
    .job      (job_head),
    .job_empty(job_empty),
    .job_pop  (job_pop),
    .result   (result),
    .empty    (empty),
    .pop      (pop)
  );

  // front reserves queue room before accepting, so the job queue never overflows
  a_job_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(job_push && (job_level == JOB_LVL_W'(JOB_DEPTH))))
    else $error("job queue overflow");

  // back only takes a job that is there
  a_job_no_underflow: assert property (@(posedge clk) disable iff (rst)
    job_pop |-> !job_empty)
    else $error("job queue underflow");

  // end of frame is always the only result of its drain transaction
  a_frame_end_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.frame_end) |-> result.run_last)
    else $error("frame_end without run_last");

endmodule

// ----- test/box_blur_3x3_edge_aware_test.sv -----
// box_blur_3x3_edge_aware_test: self-checking bench for the streaming 3x3 box blur.
// Needs bb3e_pkg and box_blur_3x3_edge_aware; every result transaction is checked against
// a built-in predictor of the pixels and frame sizes sent, or typed results from the table.
`timescale 1ns / 100ps

module box_blur_3x3_edge_aware_test;
  import bb3e_pkg::*;

  localparam int MAX_W = 1024;
  localparam int MAX_H = 4096;
  localparam int SETTLE_CYCLES = 8;      // covers in-flight work with margin
  localparam int HOLD_CYCLES = 400;      // one long stall on the result side
  localparam int RANDOM_ITEMS = 1400;
  localparam int TALL_ROWS = 48;         // rows of the one-pixel-wide frame
  localparam longint LIMIT_NS = 60_000_000;

  logic        clk;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  in_item_t    item = '0;
  logic        empty;
  logic        pop = 1'b0;
  out_item_t   result;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  box_blur_3x3_edge_aware #(.MAX_WIDTH(MAX_W), .MAX_HEIGHT(MAX_H)) dut (
    .clk(clk), .rst(rst),
    .push(push), .full(full), .item(item),
    .empty(empty), .pop(pop), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Blur predictor: its own copy of line stores, window, positions and sizes.
  // ---------------------------------------------------------------------------
  pixel_t       line_prev [MAX_W];   // row r-1
  pixel_t       line_older [MAX_W];  // row r-2
  pixel_t [8:0] win;                 // rows top/mid/bottom, columns old..new
  int           col_in, row_in, col_out;
  int           width_cfg, height_cfg;

  out_item_t expected_pixels[$];     // blurred pixels still owed by the block
  int        mismatch_count = 0;
  int        hold_request = 0;       // receiver turns this into a long pop stall
  int        frame_items = 0;        // well-formed transactions sent in frames
  int        pause_mark = -1;        // sender drains everything at this count

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 40) $display("%0t ERROR: %s", $time, what);
  endtask

  task automatic restart_frame();
    col_in = 0;
    row_in = 0;
    col_out = 0;
  endtask

  // Register write as the block sees it: field masked, then clamped to range.
  task automatic apply_size_write(input logic idx, input logic [31:0] data);
    int v;
    if (idx == REG_IMAGE_WIDTH) begin
      v = int'(data[WIDTH_REG_W-1:0]);
      width_cfg = (v < 1) ? 1 : (v > MAX_W) ? MAX_W : v;
    end else begin
      v = int'(data[HEIGHT_REG_W-1:0]);
      height_cfg = (v < 1) ? 1 : (v > MAX_H) ? MAX_H : v;
    end
    restart_frame();
  endtask

  // Average over the in-bounds cells; rv/cv bit 0 is the top row / oldest column.
  function automatic out_item_t neighbourhood_avg(input pixel_t [8:0] px,
      input logic [2:0] rv, input logic [2:0] cv, input logic fe, input logic last);
    int sr, sg, sb, cnt;
    out_item_t o;
    sr = 0; sg = 0; sb = 0; cnt = 0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (rv[i] && cv[j]) begin
          sr += int'(px[i*3+j].red);
          sg += int'(px[i*3+j].green);
          sb += int'(px[i*3+j].blue);
          cnt++;
        end
      end
    end
    if (cnt == 0) cnt = 1;
    o.out_red   = 8'((sr + cnt / 2) / cnt);
    o.out_green = 8'((sg + cnt / 2) / cnt);
    o.out_blue  = 8'((sb + cnt / 2) / cnt);
    o.frame_end = fe;
    o.run_last  = last;
    return o;
  endfunction

  // One accepted input transaction -> zero, one or two blurred pixels.
  task automatic blur_predict(input in_item_t it, output out_item_t r0,
                              output out_item_t r1, output int n);
    int           c, r, col;
    pixel_t       top, mid;
    pixel_t [8:0] sh;
    logic [2:0]   rv, cv;
    logic         e1, e2, fe;
    out_item_t    o;
    n = 0;
    r0 = '0;
    r1 = '0;
    if (it.op == OP_PIXEL) begin
      // pixels past the loaded frame are dropped until the drain finishes
      if (row_in >= height_cfg || col_in >= width_cfg) return;
      c = col_in;
      r = row_in;
      top = line_older[c];
      mid = line_prev[c];
      for (int i = 0; i < 3; i++) begin
        win[i*3+0] = win[i*3+1];
        win[i*3+1] = win[i*3+2];
      end
      win[2] = top;
      win[5] = mid;
      win[8] = {it.in_red, it.in_green, it.in_blue};
      line_older[c] = mid;
      line_prev[c] = win[8];
      e1 = (r >= 1) && (c >= 1);
      e2 = (r >= 1) && (c == width_cfg - 1);
      rv = {1'b1, 1'b1, r >= 2};
      if (e1) begin
        // centre is the middle column of the window
        cv = {1'b1, 1'b1, c >= 2};
        r0 = neighbourhood_avg(win, rv, cv, 1'b0, !e2);
        n = 1;
        col_out = c;
      end
      if (e2) begin
        // last column: centre is the newest column, nothing to its right
        for (int i = 0; i < 3; i++) begin
          sh[i*3+0] = win[i*3+1];
          sh[i*3+1] = win[i*3+2];
          sh[i*3+2] = '0;
        end
        cv = {1'b0, 1'b1, c >= 1};
        o = neighbourhood_avg(sh, rv, cv, 1'b0, 1'b1);
        if (n == 0) r0 = o;
        else r1 = o;
        n++;
        col_out = 0;
      end
      col_in = c + 1;
      if (col_in >= width_cfg) begin
        col_in = 0;
        row_in = r + 1;
      end
    end else begin
      // drain: only once the whole frame is in
      if (row_in < height_cfg || col_out >= width_cfg) return;
      rv = {1'b0, 1'b1, height_cfg >= 2};
      for (int j = 0; j < 3; j++) begin
        col = col_out + j - 1;
        cv[j] = (col >= 0) && (col < width_cfg);
        sh[j]     = cv[j] ? line_older[col] : '0;
        sh[3 + j] = cv[j] ? line_prev[col] : '0;
        sh[6 + j] = '0;
      end
      fe = (col_out == width_cfg - 1);
      r0 = neighbourhood_avg(sh, rv, cv, fe, 1'b1);
      n = 1;
      if (fe) restart_frame();
      else col_out++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // mostly short gaps, a few long ones
  function automatic int idle_len();
    int k;
    k = $urandom_range(0, 99);
    if (k < 75) return $urandom_range(1, 2);
    if (k < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] chan_value();
    int k;
    k = $urandom_range(0, 9);
    if (k == 0) return 8'h00;
    if (k == 1) return 8'hFF;
    return 8'($urandom);
  endfunction

  function automatic in_item_t rand_item(input logic op);
    in_item_t it;
    it.op = op;
    it.in_red = chan_value();
    it.in_green = chan_value();
    it.in_blue = chan_value();
    return it;
  endfunction

  // register word: size in the field, junk above it half the time
  function automatic logic [31:0] reg_word(input int val, input int nbits);
    logic [31:0] w;
    w = $urandom_range(0, 1) ? $urandom : 32'h0;
    w = ((w >> nbits) << nbits) | 32'(val);
    return w;
  endfunction

  int tx_calm = 0;

  // Offer one input transaction and hold it until the block takes it.
  // typed: queue t0/t1 (n_typed of them) instead of the predicted pixels.
  task automatic offer_item(input in_item_t it, input bit typed, input int n_typed,
                            input out_item_t t0, input out_item_t t1);
    out_item_t r0, r1;
    int        n, gap;
    item <= it;
    push <= 1'b1;
    do @(posedge clk); while (full !== 1'b0);
    blur_predict(it, r0, r1, n);
    if (typed) begin
      if (n_typed > 0) expected_pixels.push_back(t0);
      if (n_typed > 1) expected_pixels.push_back(t1);
    end else begin
      if (n > 0) expected_pixels.push_back(r0);
      if (n > 1) expected_pixels.push_back(r1);
    end
    gap = 0;
    if (tx_calm > 0) tx_calm--;
    else if ($urandom_range(0, 99) < 15) gap = idle_len();
    if ($urandom_range(0, 999) == 0) tx_calm = 200;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic tx_quiet();
    push <= 1'b0;
    @(posedge clk);
  endtask

  // idle the block: nothing owed, then room for in-flight work that owes nothing
  task automatic settle();
    tx_quiet();
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write, then read back the clamped value
  task automatic cfg_write(input logic idx, input logic [31:0] data);
    int want;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    apply_size_write(idx, data);
    want = (idx == REG_IMAGE_WIDTH) ? width_cfg : height_cfg;
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (prdata !== 32'(want))
      report_mismatch($sformatf("reg %0d read %0h, want %0h", idx, prdata, want));
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // One frame at the current size: pixels in raster order, then one drain per
  // column of the last row. Sprinkled noise is ignored by the block.
  task automatic run_frame(input bit may_abandon, output bit complete);
    int total, cut;
    total = width_cfg * height_cfg;
    cut = total;
    if (may_abandon && $urandom_range(0, 99) < 8) cut = $urandom_range(0, total - 1);
    for (int k = 0; k < cut; k++) begin
      if ($urandom_range(0, 99) < 3)  // drain too early
        offer_item(rand_item(OP_DRAIN), 1'b0, 0, '0, '0);
      if (frame_items == pause_mark) begin
        // sender steps back until every owed pixel is out
        tx_quiet();
        while (expected_pixels.size() != 0) @(posedge clk);
      end
      offer_item(rand_item(OP_PIXEL), 1'b0, 0, '0, '0);
      frame_items++;
    end
    complete = (cut == total);
    if (!complete) return;  // partial frame, dropped by the next register write
    for (int d = 0; d < width_cfg; d++) begin
      if ($urandom_range(0, 99) < 3)  // pixel while the frame drains
        offer_item(rand_item(OP_PIXEL), 1'b0, 0, '0, '0);
      offer_item(rand_item(OP_DRAIN), 1'b0, 0, '0, '0);
      frame_items++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Directed table
  // ---------------------------------------------------------------------------
  typedef struct {
    bit          is_cfg;
    logic        cfg_idx;
    logic [31:0] cfg_data;
    in_item_t    stim;
    int          n_typed;   // -1: predictor decides
    out_item_t   t0;
    out_item_t   t1;
  } dir_row_t;

  dir_row_t directed_plan[$];

  function automatic out_item_t px_out(input logic [7:0] r, input logic [7:0] g,
      input logic [7:0] b, input logic fe, input logic last);
    return {r, g, b, fe, last};
  endfunction

  function automatic dir_row_t item_row(input logic op, input logic [23:0] rgb,
      input int n_typed, input out_item_t t0);
    dir_row_t row;
    row.is_cfg = 1'b0;
    row.cfg_idx = REG_IMAGE_WIDTH;
    row.cfg_data = '0;
    row.stim = {op, rgb};
    row.n_typed = n_typed;
    row.t0 = t0;
    row.t1 = '0;
    return row;
  endfunction

  function automatic dir_row_t cfg_row(input logic idx, input logic [31:0] data);
    dir_row_t row;
    row = item_row(OP_PIXEL, '0, 0, '0);
    row.is_cfg = 1'b1;
    row.cfg_idx = idx;
    row.cfg_data = data;
    return row;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: checks each popped transaction, idles pop at random.
  // ---------------------------------------------------------------------------
  initial begin : result_side
    int        idle_left, calm_left, hold_left, seen;
    out_item_t want;
    idle_left = 0;
    calm_left = 0;
    hold_left = 0;
    seen = 0;
    forever begin
      @(posedge clk);
      if (!rst && pop && !empty) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing owed: %h", seen, result));
        end else begin
          want = expected_pixels.pop_front();
          if (result.out_red !== want.out_red || result.out_green !== want.out_green ||
              result.out_blue !== want.out_blue || result.frame_end !== want.frame_end ||
              result.run_last !== want.run_last)
            report_mismatch($sformatf(
              "result %0d: got rgb %h_%h_%h fe %b last %b, want rgb %h_%h_%h fe %b last %b",
              seen, result.out_red, result.out_green, result.out_blue, result.frame_end,
              result.run_last, want.out_red, want.out_green, want.out_blue,
              want.frame_end, want.run_last));
        end
        seen++;
      end
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (idle_left > 0) begin
        idle_left--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
        if (calm_left > 0) calm_left--;
        else if ($urandom_range(0, 99) < 20) idle_left = idle_len();
        if ($urandom_range(0, 499) == 0) calm_left = 150;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int start, phase, w, h;
    bit done;

    foreach (line_prev[i]) begin
      line_prev[i] = '0;
      line_older[i] = '0;
    end
    win = '0;
    width_cfg = 1;
    height_cfg = 1;
    restart_frame();

    // After reset the frame is 1x1: a lone pixel blurs to itself.
    directed_plan.push_back(item_row(OP_DRAIN, 24'h000000, 0, '0));  // not loaded yet
    directed_plan.push_back(item_row(OP_PIXEL, 24'hFFFFFF, 0, '0));
    directed_plan.push_back(item_row(OP_PIXEL, 24'h000000, 0, '0));  // frame full, dropped
    directed_plan.push_back(item_row(OP_DRAIN, 24'h123456, 1,
                                     px_out(8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1)));
    directed_plan.push_back(item_row(OP_DRAIN, 24'h000000, 0, '0));  // frame over
    directed_plan.push_back(item_row(OP_PIXEL, 24'h000000, 0, '0));
    directed_plan.push_back(item_row(OP_DRAIN, 24'hFFFFFF, 1,
                                     px_out(8'h00, 8'h00, 8'h00, 1'b1, 1'b1)));
    // 2x1, height field zero with junk above it: halves round up
    directed_plan.push_back(cfg_row(REG_IMAGE_WIDTH, 32'd2));
    directed_plan.push_back(cfg_row(REG_IMAGE_HEIGHT, 32'hFFFF_E000));
    directed_plan.push_back(item_row(OP_PIXEL, 24'h000000, 0, '0));
    directed_plan.push_back(item_row(OP_PIXEL, 24'h01FFFE, 0, '0));
    directed_plan.push_back(item_row(OP_DRAIN, 24'h000000, 1,
                                     px_out(8'h01, 8'h80, 8'h7F, 1'b0, 1'b1)));
    directed_plan.push_back(item_row(OP_DRAIN, 24'h000000, 1,
                                     px_out(8'h01, 8'h80, 8'h7F, 1'b1, 1'b1)));
    // 3x3: corners, edges, centre, double results at the row end
    directed_plan.push_back(cfg_row(REG_IMAGE_WIDTH, 32'd3));
    directed_plan.push_back(cfg_row(REG_IMAGE_HEIGHT, 32'd3));
    directed_plan.push_back(item_row(OP_PIXEL, 24'hFF0000, -1, '0));
    directed_plan.push_back(item_row(OP_PIXEL, 24'h00FF00, -1, '0));
    directed_plan.push_back(item_row(OP_PIXEL, 24'h0000FF, -1, '0));
    directed_plan.push_back(item_row(OP_PIXEL, 24'hFFFFFF, -1, '0));
    directed_plan.push_back(item_row(OP_PIXEL, 24'h000000, -1, '0));
    directed_plan.push_back(item_row(OP_PIXEL, 24'h808080, -1, '0));
    directed_plan.push_back(item_row(OP_PIXEL, 24'h7F7F7F, -1, '0));
    directed_plan.push_back(item_row(OP_PIXEL, 24'h010203, -1, '0));
    directed_plan.push_back(item_row(OP_PIXEL, 24'hFEFDFC, -1, '0));
    directed_plan.push_back(item_row(OP_DRAIN, 24'h000000, -1, '0));
    directed_plan.push_back(item_row(OP_DRAIN, 24'h000000, -1, '0));
    directed_plan.push_back(item_row(OP_DRAIN, 24'h000000, -1, '0));

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_plan[i]) begin
      if (directed_plan[i].is_cfg) begin
        settle();
        cfg_write(directed_plan[i].cfg_idx, directed_plan[i].cfg_data);
      end else begin
        offer_item(directed_plan[i].stim, directed_plan[i].n_typed >= 0,
                   directed_plan[i].n_typed, directed_plan[i].t0, directed_plan[i].t1);
      end
    end

    // Size extremes: fields above range clamp down and read back as the
    // maxima, then a tall frame one pixel wide (zero width clamps up).
    settle();
    cfg_write(REG_IMAGE_WIDTH, 32'd2047);
    cfg_write(REG_IMAGE_HEIGHT, 32'd8191);
    cfg_write(REG_IMAGE_WIDTH, 32'd0);
    cfg_write(REG_IMAGE_HEIGHT, 32'(TALL_ROWS));
    run_frame(1'b0, done);

    // Random frames, mostly small; the first one runs into a long pop stall
    // so the block backs up and pushes full.
    start = frame_items;
    pause_mark = start + 300;
    phase = 0;
    while (frame_items - start < RANDOM_ITEMS) begin
      settle();
      if (phase == 0) begin
        w = 12;
        h = 6;
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: begin
            w = $urandom_range(1, 8);
            h = $urandom_range(1, 5);
          end
          6, 7, 8: begin
            w = $urandom_range(9, 32);
            h = $urandom_range(6, 12);
          end
          default: begin
            w = $urandom_range(33, 64);
            h = $urandom_range(13, 20);
          end
        endcase
        if ($urandom_range(0, 19) == 0) w = 0;
        if ($urandom_range(0, 19) == 0) h = 0;
      end
      if ($urandom_range(0, 1)) begin
        cfg_write(REG_IMAGE_WIDTH, reg_word(w, WIDTH_REG_W));
        cfg_write(REG_IMAGE_HEIGHT, reg_word(h, HEIGHT_REG_W));
      end else begin
        cfg_write(REG_IMAGE_HEIGHT, reg_word(h, HEIGHT_REG_W));
        cfg_write(REG_IMAGE_WIDTH, reg_word(w, WIDTH_REG_W));
      end
      if (phase == 0) hold_request = HOLD_CYCLES;
      // back-to-back frames without a register write now and then
      do run_frame(1'b1, done); while (done && $urandom_range(0, 99) < 30);
      phase++;
    end

    tx_quiet();
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // hard stop if the block hangs
  initial begin : watchdog
    #(LIMIT_NS);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/bb3e_pkg.sv
rtl/bb3e_front.sv
rtl/bb3e_job_fifo.sv
rtl/bb3e_back.sv
rtl/box_blur_3x3_edge_aware.sv
test/box_blur_3x3_edge_aware_test.sv
